@@ hdl/sample_mean_stddev_max_defines.svh @@
// assertion macros for the sample statistics block
`ifndef SAMPLE_MEAN_STDDEV_MAX_DEFINES_SVH
`define SAMPLE_MEAN_STDDEV_MAX_DEFINES_SVH
`ifndef ASSERT_OFF
`define SMSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SMSM_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define SMSM_ASSERT(lbl, prop, msg)
`define SMSM_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

@@ hdl/smsm_pkg.sv @@
package smsm_pkg;

  localparam logic [29:0] SampleMin = 30'd1;
  localparam logic [29:0] SampleMax = 30'd1000000000;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusFew     = 2'd1;
  localparam logic [1:0] StatusDropped = 2'd2;

  typedef struct packed {
    logic [29:0] sample;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [29:0] mean_value;
    logic [29:0] std_dev;
    logic [29:0] largest_value;
    logic [4:0]  sample_count;
    logic [1:0]  status;
  } result_t;

  // accumulated totals of one finished set
  typedef struct packed {
    logic [33:0] sum;
    logic [63:0] sum_sq;
    logic [29:0] max;
    logic [4:0]  count;
    logic        dropped;
  } snap_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

@@ hdl/smsm_front.sv @@
module smsm_front #(
  parameter int MaxSamples = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  smsm_pkg::in_item_t item_i,
  output logic             full_o,
  output smsm_pkg::snap_t  snap_o,
  output logic             snap_push_o,
  input  logic             snap_full_i
);
  import smsm_pkg::*;

  logic        s1_v_q;
  logic        s1_last_q;
  logic [29:0] s1_smp_q;
  logic [29:0] clamp;
  logic        stall;

  logic [33:0] sum_q, sum_d;
  logic [63:0] sq_q, sq_d;
  logic [29:0] max_q, max_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        drop_q, drop_d;
  logic [59:0] square;

  assign stall  = s1_v_q & s1_last_q & snap_full_i;
  assign full_o = stall;

  always_comb begin
    clamp = item_i.sample;
    if (clamp < SampleMin) clamp = SampleMin;
    if (clamp > SampleMax) clamp = SampleMax;
  end

  assign square = 60'(s1_smp_q) * 60'(s1_smp_q);

  always_comb begin
    sum_d  = sum_q;
    sq_d   = sq_q;
    max_d  = max_q;
    cnt_d  = cnt_q;
    drop_d = drop_q;
    if (cnt_q < 5'(MaxSamples)) begin
      sum_d = sum_q + 34'(s1_smp_q);
      sq_d  = sq_q + 64'(square);
      if (s1_smp_q > max_q) max_d = s1_smp_q;
      cnt_d = cnt_q + 5'd1;
    end else begin
      drop_d = 1'b1;
    end
  end

  assign snap_o      = '{sum: sum_d, sum_sq: sq_d, max: max_d, count: cnt_d, dropped: drop_d};
  assign snap_push_o = s1_v_q & s1_last_q & ~snap_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      sum_q  <= '0;
      sq_q   <= '0;
      max_q  <= '0;
      cnt_q  <= '0;
      drop_q <= 1'b0;
    end else if (!stall) begin
      s1_v_q <= push_i;
      if (s1_v_q) begin
        if (s1_last_q) begin
          sum_q  <= '0;
          sq_q   <= '0;
          max_q  <= '0;
          cnt_q  <= '0;
          drop_q <= 1'b0;
        end else begin
          sum_q  <= sum_d;
          sq_q   <= sq_d;
          max_q  <= max_d;
          cnt_q  <= cnt_d;
          drop_q <= drop_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      s1_smp_q  <= clamp;
      s1_last_q <= item_i.last;
    end
  end

endmodule

@@ hdl/smsm_fifo.sv @@
module smsm_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  smsm_pkg::snap_t data_i,
  output logic            full_o,
  output smsm_pkg::hs_t   hs_o,
  input  logic            pop_i,
  output smsm_pkg::snap_t data_o
);
  import smsm_pkg::*;

  snap_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o     = cnt_q[1];
  assign hs_o.valid = (cnt_q != 2'd0);
  assign hs_o.ready = ~cnt_q[1];
  assign data_o     = mem_q[rd_q];
  assign do_push    = push_i & ~cnt_q[1];
  assign do_pop     = pop_i & (cnt_q != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      if (do_push & ~do_pop) cnt_q <= cnt_q + 2'd1;
      else if (do_pop & ~do_push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

@@ hdl/smsm_back.sv @@
module smsm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  smsm_pkg::hs_t     snap_hs_i,
  input  smsm_pkg::snap_t   snap_i,
  output logic              snap_pop_o,
  output smsm_pkg::result_t res_o,
  output logic              empty_o,
  input  logic              pop_i
);
  import smsm_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StSub  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StSqrt = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0]  st_q;
  logic [6:0]  cnt_q;
  logic        out_v_q;
  result_t     res_q;

  logic [33:0] mulr_q;
  logic [33:0] sum_q;
  logic [29:0] max_q;
  logic [4:0]  n_q;
  logic        drop_q;
  logic [67:0] nq_q;
  logic [67:0] ss_q;
  logic [33:0] mdiv_q;
  logic [4:0]  mrem_q;
  logic [67:0] vdiv_q;
  logic [7:0]  vrem_q;
  logic [7:0]  d_q;
  logic [63:0] sv_q, sres_q, sbit_q;

  logic [5:0]  m_r;
  logic        m_ge;
  logic [8:0]  v_r;
  logic        v_ge;
  logic [63:0] s_t;
  logic        s_ge;
  logic        out_free;
  logic [1:0]  status;

  assign m_r  = {mrem_q, mdiv_q[33]};
  assign m_ge = m_r >= {1'b0, n_q};
  assign v_r  = {vrem_q, vdiv_q[67]};
  assign v_ge = v_r >= {1'b0, d_q};
  assign s_t  = sres_q + sbit_q;
  assign s_ge = sv_q >= s_t;

  assign out_free   = ~out_v_q | pop_i;
  assign snap_pop_o = (st_q == StIdle) & snap_hs_i.valid;
  assign empty_o    = ~out_v_q;
  assign res_o      = res_q;

  always_comb begin
    priority if (drop_q) status = StatusDropped;
    else if (n_q < 5'd2) status = StatusFew;
    else status = StatusOk;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (pop_i) out_v_q <= 1'b0;
      unique case (st_q)
        StIdle: if (snap_hs_i.valid) begin
          st_q  <= StMul;
          cnt_q <= 7'd33;
        end
        StMul: begin
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == 7'd0) st_q <= (n_q >= 5'd2) ? StSub : StOut;
        end
        StSub: begin
          st_q  <= StDiv;
          cnt_q <= 7'd67;
        end
        StDiv: begin
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == 7'd0) begin
            st_q  <= StSqrt;
            cnt_q <= 7'd31;
          end
        end
        StSqrt: begin
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == 7'd0) st_q <= StOut;
        end
        StOut: if (out_free) begin
          st_q    <= StIdle;
          out_v_q <= 1'b1;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: begin
        sum_q  <= snap_i.sum;
        mulr_q <= snap_i.sum;
        mdiv_q <= snap_i.sum;
        max_q  <= snap_i.max;
        n_q    <= snap_i.count;
        drop_q <= snap_i.dropped;
        nq_q   <= 68'(snap_i.sum_sq) * 68'(snap_i.count);
        ss_q   <= '0;
        mrem_q <= '0;
        sres_q <= '0;
      end
      StMul: begin
        // shift-add square of the sum, alongside the mean division
        ss_q   <= {ss_q[66:0], 1'b0} + (mulr_q[33] ? 68'(sum_q) : 68'd0);
        mulr_q <= {mulr_q[32:0], 1'b0};
        mrem_q <= m_ge ? 5'(m_r - {1'b0, n_q}) : m_r[4:0];
        mdiv_q <= {mdiv_q[32:0], m_ge};
      end
      StSub: begin
        vdiv_q <= nq_q - ss_q;
        vrem_q <= '0;
        d_q    <= 8'(10'(n_q) * 10'(n_q - 5'd1));
      end
      StDiv: begin
        vrem_q <= v_ge ? 8'(v_r - {1'b0, d_q}) : v_r[7:0];
        vdiv_q <= {vdiv_q[66:0], v_ge};
        if (cnt_q == 7'd0) begin
          sv_q   <= {vdiv_q[62:0], v_ge};
          sres_q <= '0;
          sbit_q <= 64'd1 << 62;
        end
      end
      StSqrt: begin
        if (s_ge) begin
          sv_q   <= sv_q - s_t;
          sres_q <= (sres_q >> 1) + sbit_q;
        end else begin
          sres_q <= sres_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
      end
      StOut: if (out_free) begin
        res_q.mean_value    <= (n_q == 5'd0) ? 30'd0 : mdiv_q[29:0];
        res_q.std_dev       <= sres_q[29:0];
        res_q.largest_value <= (n_q == 5'd0) ? 30'd0 : max_q;
        res_q.sample_count  <= n_q;
        res_q.status        <= status;
      end
      default: ;
    endcase
  end

endmodule

@@ hdl/sample_mean_stddev_max.sv @@
// sample statistics: mean, sample standard deviation and maximum of a set
// input channel: push_i / full_o carry one sample item per cycle; an item
// with last set closes the set. samples are clamped to 1..1000000000 and
// samples past MaxSamples in one set are dropped (status reports it).
// result channel: empty_o low means res_o holds the oldest result; pop_i
// takes it. one result per closed set.
// throughput: one sample per cycle while full_o is low. the front
// accumulates sum, sum of squares, max and count in a two-stage pipe,
// then hands the totals of a finished set to a two-entry queue.
// the back unit works one set at a time: a load step, shift-add square
// and mean division, then for two or more samples a subtract step,
// bit-serial variance division and square root, then a step into the
// output register.
// reset clears the accumulators, the queue and the output valid flag.
// when the receiver stalls, the result holds; the back unit then waits,
// and once the queue is full a closing item holds full_o high.
module sample_mean_stddev_max #(
  parameter int MaxSamples = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  smsm_pkg::in_item_t in_item_i,
  output logic              full_o,
  output logic              empty_o,
  input  logic              pop_i,
  output smsm_pkg::result_t res_o
);
  import smsm_pkg::*;

`include "sample_mean_stddev_max_defines.svh"

  snap_t snap_w, snap_r;
  logic  snap_push, snap_full, snap_pop;
  hs_t   snap_hs;

  smsm_front #(.MaxSamples(MaxSamples)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .item_i      (in_item_i),
    .full_o      (full_o),
    .snap_o      (snap_w),
    .snap_push_o (snap_push),
    .snap_full_i (snap_full)
  );

  smsm_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (snap_push),
    .data_i (snap_w),
    .full_o (snap_full),
    .hs_o   (snap_hs),
    .pop_i  (snap_pop),
    .data_o (snap_r)
  );

  smsm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .snap_hs_i  (snap_hs),
    .snap_i     (snap_r),
    .snap_pop_o (snap_pop),
    .res_o      (res_o),
    .empty_o    (empty_o),
    .pop_i      (pop_i)
  );

  `SMSM_ASSERT(a_count_range, !empty_o |-> (res_o.sample_count >= 5'd1 && res_o.sample_count <= 5'(MaxSamples)), "result count out of range")
  `SMSM_ASSERT(a_ok_needs_two, (!empty_o && res_o.status == StatusOk) |-> res_o.sample_count >= 5'd2, "ok status with fewer than two samples")
  `SMSM_ASSERT(a_sd_le_max, !empty_o |-> (res_o.std_dev <= res_o.largest_value && res_o.mean_value <= res_o.largest_value), "mean or deviation above maximum")
  `SMSM_ASSERT_NEVER(a_status_code, !empty_o && res_o.status == 2'd3, "undefined status code")

endmodule

@@ bench/sample_stats_checker.sv @@
`timescale 1ns / 1ps

module sample_stats_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               full_i,
  input  smsm_pkg::in_item_t in_item_i,
  input  logic               empty_i,
  input  logic               pop_i,
  input  smsm_pkg::result_t  res_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 sets_seen_o
);
  import smsm_pkg::*;

  localparam int MaxSamples = 16;

  logic [33:0] acc_sum;
  logic [63:0] acc_sum_sq;
  logic [29:0] acc_max;
  logic [4:0]  acc_count;
  logic        acc_dropped;
  result_t     expected_stats[$];

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // closes the set: returns the stats expected from the current totals
  function automatic result_t close_set();
    result_t r;
    logic [127:0] spread;
    logic [63:0]  n;
    n = 64'(acc_count);
    r = '0;
    if (n != 0) begin
      r.mean_value    = 30'(64'(acc_sum) / n);
      r.largest_value = acc_max;
    end
    if (n >= 2) begin
      spread   = 128'(acc_sum_sq) * 128'(n) - 128'(acc_sum) * 128'(acc_sum);
      r.std_dev = 30'(floor_sqrt(64'(spread / 128'(n * (n - 1)))));
    end
    r.sample_count = acc_count;
    r.status = acc_dropped ? StatusDropped : (n < 2 ? StatusFew : StatusOk);
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [29:0] s;
    result_t     want;
    if (!rst_ni) begin
      acc_sum = '0; acc_sum_sq = '0; acc_max = '0; acc_count = '0;
      acc_dropped = 1'b0;
      fail_count_o <= 0;
      sets_seen_o <= 0;
      expected_stats.delete();
    end else begin
      if (push_i && !full_i) begin
        s = in_item_i.sample;
        if (s < SampleMin) s = SampleMin;
        if (s > SampleMax) s = SampleMax;
        if (acc_count < MaxSamples) begin
          acc_sum = acc_sum + 34'(s);
          acc_sum_sq = acc_sum_sq + 64'(s) * 64'(s);
          if (s > acc_max) acc_max = s;
          acc_count = acc_count + 5'd1;
        end else begin
          acc_dropped = 1'b1;
        end
        if (in_item_i.last) begin
          expected_stats.push_back(close_set());
          acc_sum = '0; acc_sum_sq = '0; acc_max = '0; acc_count = '0;
          acc_dropped = 1'b0;
        end
      end
      if (pop_i && !empty_i) begin
        sets_seen_o <= sets_seen_o + 1;
        if (expected_stats.size() == 0) begin
          $display("%0t: unexpected result %p", $time, res_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_stats.pop_front();
          if (res_i !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, res_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = expected_stats.size();
endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import smsm_pkg::*;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     push_i = 1'b0;
  logic     pop_i = 1'b0;
  in_item_t in_item_i = '0;
  logic     full_o, empty_o;
  result_t  res_o;
  int       fail_count, pending, sets_seen;
  int       cycle_count = 0;
  int       items_sent = 0;
  logic     held = 1'b0;

  sample_mean_stddev_max dut (
    .clk_i, .rst_ni, .push_i, .in_item_i, .full_o, .empty_o, .pop_i, .res_o
  );

  sample_stats_checker checker_i (
    .clk_i, .rst_ni, .push_i, .full_i(full_o), .in_item_i, .empty_i(empty_o),
    .pop_i, .res_i(res_o), .fail_count_o(fail_count), .pending_o(pending),
    .sets_seen_o(sets_seen)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [29:0] rand_sample();
    case ($urandom_range(0, 6))
      0: return 30'($urandom_range(0, 3));
      1: return 30'($urandom_range(999999990, 1000000010));
      2: return 30'($urandom) | 30'h3FFF_0000;
      3: return 30'($urandom_range(0, 2000));
      default: return 30'($urandom);
    endcase
  endfunction

  // push stays high between back-to-back items
  task automatic send_item(input logic [29:0] s, input logic lst);
    int g;
    g = gap_len();
    if (g > 0) begin
      push_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    push_i <= 1'b1;
    in_item_i <= '{sample: s, last: lst};
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    items_sent++;
  endtask

  // one set of n samples, the final one closing it
  task automatic send_set(input int n);
    for (int i = 0; i < n; i++) send_item(rand_sample(), i == n - 1);
  endtask

  // receiver: random pops, one long hold-off partway through
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      if (!held && items_sent >= 600) begin
        held = 1'b1;
        pop_i <= 1'b0;
        repeat (3000) @(posedge clk_i);
      end
      g = gap_len();
      if (g > 0) begin
        pop_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      pop_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin
    int n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // extremes and special cases: clamp low/high, single sample, equal samples
    send_item(30'd0, 1'b1);
    send_item(30'h3FFF_FFFF, 1'b1);
    send_item(30'd1000000000, 1'b0);
    send_item(30'd0, 1'b1);
    send_item(30'd1000000001, 1'b0);
    send_item(30'd1000000000, 1'b1);
    send_item(30'd5, 1'b0);
    send_item(30'd5, 1'b0);
    send_item(30'd5, 1'b1);
    // overfull set: dropped samples
    for (int i = 0; i < 18; i++) send_item(i[0] ? 30'h3FFF_FFFF : 30'd0, i == 17);
    while (items_sent < 1650) begin
      case ($urandom_range(0, 9))
        0: n = 1;
        1: n = $urandom_range(17, 24);
        2: n = 16;
        default: n = $urandom_range(2, 15);
      endcase
      send_set(n);
    end
    push_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("sent %0d sample items, checked %0d result sets", items_sent, sets_seen);
    $display("covered clamping, single-sample and overfull sets, and a long stall");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end
endmodule
